// File: rtl/core/bums_pkg.sv
// Shared types and constants for the bottom-up merge sorter.
// Holds the beat structs, the engine command struct and the sizing constants.
// No dependencies; every other file of the block imports this package.
package bums_pkg;

    // Number of values one set can hold, and the stored value width.
    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;

    // Width of the value fields on the ports.
    localparam int VALUE_W = 32;

    // Memory index, element count (holds DEPTH itself) and wide run pointer sums.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = CNT_W + 2;

    typedef logic [DATA_WIDTH-1:0] bums_elem_t;

    // One input beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } bums_item_t;

    // One output beat.
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      end_of_list;
    } bums_result_t;

    // Control from the top-level sequencer to the merge engine.
    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_addr;
        logic             start;
        logic [CNT_W-1:0] n;
        logic [IDX_W-1:0] drain_addr;
    } bums_cmd_t;

endpackage

// File: rtl/core/bums_merge_engine.sv
// Merge engine: two element memories used as ping-pong banks and one shared
// compare-and-select unit stepped by a small sequencer, one pass per run width.
// Depends on bums_pkg for the command struct and sizing constants.
module bums_merge_engine
    import bums_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bums_cmd_t  cmd,
    input  bums_elem_t load_data,
    output bums_elem_t rdata,
    output logic       busy
);

    typedef enum logic [2:0] {
        E_IDLE  = 3'b001,
        E_READ  = 3'b010,
        E_MERGE = 3'b100
    } eng_state_t;

    eng_state_t state_reg, state_next;
    logic       src_b_reg, src_b_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [CNT_W-1:0] a_reg, a_next;
    logic [CNT_W-1:0] b_reg, b_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] end_reg, end_next;
    logic [CNT_W-1:0] o_reg, o_next;

    // Element banks and their registered read ports.
    bums_elem_t mem_a [DEPTH];
    bums_elem_t mem_b [DEPTH];
    bums_elem_t rd0_a_reg, rd1_a_reg, rd0_b_reg, rd1_b_reg;

    bums_elem_t da, db, wr_data;
    logic       take_a, merging;
    logic [CNT_W-1:0] o_inc;
    logic       run_done, pass_done, sort_done;
    logic [PTR_W-1:0] w2;

    logic [CNT_W-1:0] base_sel, w_sel, n_sel, mid_set, end_set;
    logic [PTR_W-1:0] sum_mid, sum_end;

    logic             we_a;
    logic [IDX_W-1:0] wa_a, ra0, ra1;
    bums_elem_t       wd_a;

    assign busy    = (state_reg != E_IDLE);
    assign merging = (state_reg == E_MERGE);

    // Operands come from the current source bank.
    assign da = src_b_reg ? rd0_b_reg : rd0_a_reg;
    assign db = src_b_reg ? rd1_b_reg : rd1_a_reg;

    // Shared compare: the left run wins ties, which keeps the sort stable.
    assign take_a  = (a_reg < mid_reg) &&
                     ((b_reg >= end_reg) || !($signed(db) < $signed(da)));
    assign wr_data = take_a ? da : db;

    // Run and pass bookkeeping.
    assign o_inc     = o_reg + 1'b1;
    assign run_done  = (o_inc == end_reg);
    assign pass_done = run_done && (end_reg == n_reg);
    assign w2        = PTR_W'({w_reg, 1'b0});
    assign sort_done = pass_done && (w2 >= PTR_W'(n_reg));

    // Bounds of the next run pair, clipped to the element count.
    always_comb
    begin
        if (state_reg == E_IDLE)
        begin
            base_sel = '0;
            w_sel    = CNT_W'(1);
            n_sel    = cmd.n;
        end
        else
        begin
            base_sel = pass_done ? '0 : end_reg;
            w_sel    = pass_done ? CNT_W'(w2) : w_reg;
            n_sel    = n_reg;
        end
        sum_mid = PTR_W'(base_sel) + PTR_W'(w_sel);
        sum_end = sum_mid + PTR_W'(w_sel);
        mid_set = (sum_mid > PTR_W'(n_sel)) ? n_sel : CNT_W'(sum_mid);
        end_set = (sum_end > PTR_W'(n_sel)) ? n_sel : CNT_W'(sum_end);
    end

    // Sequencer: read both run heads, then compare and write one element.
    always_comb
    begin
        state_next = state_reg;
        src_b_next = src_b_reg;
        n_next     = n_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        mid_next   = mid_reg;
        end_next   = end_reg;
        o_next     = o_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next     = cmd.n;
                    w_next     = w_sel;
                    src_b_next = 1'b0;
                    a_next     = base_sel;
                    b_next     = mid_set;
                    mid_next   = mid_set;
                    end_next   = end_set;
                    o_next     = base_sel;
                    if (cmd.n > CNT_W'(1))
                    begin
                        state_next = E_READ;
                    end
                end
            end
            E_READ:
            begin
                state_next = E_MERGE;
            end
            E_MERGE:
            begin
                o_next = o_inc;
                if (take_a)
                begin
                    a_next = a_reg + 1'b1;
                end
                else
                begin
                    b_next = b_reg + 1'b1;
                end
                state_next = E_READ;
                if (run_done)
                begin
                    if (sort_done)
                    begin
                        src_b_next = ~src_b_reg;
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        if (pass_done)
                        begin
                            src_b_next = ~src_b_reg;
                        end
                        w_next   = w_sel;
                        a_next   = base_sel;
                        b_next   = mid_set;
                        mid_next = mid_set;
                        end_next = end_set;
                        o_next   = base_sel;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            src_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_b_reg <= src_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        w_reg   <= w_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        mid_reg <= mid_next;
        end_reg <= end_next;
        o_reg   <= o_next;
    end

    // Memory ports: bank A also takes the loaded values.
    assign we_a = cmd.load_we || (merging && src_b_reg);
    assign wa_a = cmd.load_we ? cmd.load_addr : o_reg[IDX_W-1:0];
    assign wd_a = cmd.load_we ? load_data : wr_data;
    assign ra0  = busy ? a_reg[IDX_W-1:0] : cmd.drain_addr;
    assign ra1  = b_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we_a)
        begin
            mem_a[wa_a] <= wd_a;
        end
        if (merging && !src_b_reg)
        begin
            mem_b[o_reg[IDX_W-1:0]] <= wr_data;
        end
        rd0_a_reg <= mem_a[ra0];
        rd1_a_reg <= mem_a[ra1];
        rd0_b_reg <= mem_b[ra0];
        rd1_b_reg <= mem_b[ra1];
    end

    // When idle the source bank is the one that holds the sorted list.
    assign rdata = src_b_reg ? rd0_b_reg : rd0_a_reg;

endmodule

// File: rtl/core/bottom_up_merge_sorter_unit.sv
// Bottom-up merge sorter: load sequencer, drain sequencer and output register.
// Sorting runs in bums_merge_engine; types and constants come from bums_pkg.
//
// Usage: values arrive on the item channel, one per beat, until a beat with
// last set. Up to DEPTH values are kept; further values are dropped, but a
// last beat still starts the sort. The set of n values then leaves on the
// result channel in ascending signed order, end_of_list set on the final beat.
// Sorting takes ceil(log2 n) passes; for each element of a pass the shared
// compare unit reads both run heads, then compares and writes. Draining
// reads each beat through the registered memory read before loading it
// into the output register, one beat at a time. item_stall is high from the
// last beat until the final result is loaded into the output register. A
// stall on the result channel holds the output register and pauses the
// drain. Reset empties the set and the output register; memory contents are
// not cleared.
module bottom_up_merge_sorter_unit
    import bums_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  bums_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output bums_result_t result
);

    typedef enum logic [3:0] {
        S_LOAD      = 4'b0001,
        S_SORT      = 4'b0010,
        S_DRAIN_RD  = 4'b0100,
        S_DRAIN_OUT = 4'b1000
    } top_state_t;

    top_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic         out_valid_reg, out_valid_next;
    bums_result_t out_reg, out_next;

    bums_cmd_t  cmd;
    bums_elem_t rdata;
    logic       busy;
    logic       accept, room, out_free;
    logic [CNT_W-1:0] count_inc;

    bums_merge_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .load_data (DATA_WIDTH'(item.value)),
        .rdata     (rdata),
        .busy      (busy)
    );

    // Input handshake and store fill.
    assign item_stall = (state_reg != S_LOAD);
    assign accept     = item_valid && !item_stall;
    assign room       = (count_reg < CNT_W'(DEPTH));
    assign count_inc  = count_reg + CNT_W'(room);
    assign out_free   = !out_valid_reg || !result_stall;

    always_comb
    begin
        cmd.load_we    = accept && room;
        cmd.load_addr  = count_reg[IDX_W-1:0];
        cmd.start      = accept && item.last;
        cmd.n          = count_inc;
        cmd.drain_addr = k_reg[IDX_W-1:0];
    end

    // Load, sort and drain sequencer.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_next       = out_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    count_next = count_inc;
                    if (item.last)
                    begin
                        k_next     = '0;
                        state_next = S_SORT;
                    end
                end
            end
            S_SORT:
            begin
                if (!busy)
                begin
                    state_next = S_DRAIN_RD;
                end
            end
            S_DRAIN_RD:
            begin
                state_next = S_DRAIN_OUT;
            end
            S_DRAIN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next.sorted_value    = VALUE_W'(rdata);
                    out_next.end_of_list     = (k_reg + 1'b1 == count_reg);
                    if (k_reg + 1'b1 == count_reg)
                    begin
                        count_next = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_DRAIN_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// File: rtl/core/bums_checker.sv
// Port-level checker for the bottom-up merge sorter and its bind statement.
// Depends on bums_pkg for the beat types and on bottom_up_merge_sorter_unit.
module bums_checker
    import bums_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         item_valid,
    input logic         item_stall,
    input bums_item_t   item,
    input logic         result_valid,
    input logic         result_stall,
    input bums_result_t result
);

    // A stalled result beat stays valid and unchanged.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // The beat that closes a set blocks further input while sorting starts.
    a_last_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.last |=> item_stall)
        else $error("input taken right after the closing beat");

    // While a set is still draining, no new input is taken.
    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.end_of_list |-> item_stall)
        else $error("input open while a set is still draining");

endmodule

bind bottom_up_merge_sorter_unit bums_checker u_bums_checker (.*);

// File: tb/bottom_up_merge_sorter_unit_test.sv
`timescale 1ns / 1ps
// Testbench for bottom_up_merge_sorter_unit: sends sets of signed values, predicts the
// sorted beats in a scoreboard class and checks every result beat field by field.
// Depends on bums_pkg and the bottom_up_merge_sorter_unit RTL only.
module bottom_up_merge_sorter_unit_test;
    import bums_pkg::*;

    typedef logic signed [VALUE_W-1:0] word_t;
    typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_EXTREME} fill_mode_t;

    localparam int ITEM_TARGET    = 480;
    localparam int HOLD_CYCLES    = 1200;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int TAIL_CYCLES    = 500;
    localparam int MAX_REPORTS    = 40;

    // Holds the set being collected and the sorted beats still to arrive.
    class sorted_set_scoreboard;
        logic signed [63:0] open_set[$];
        bums_result_t       sorted_beats[$];
        int                 mismatch_count;
        int                 beat_index;

        function new();
            mismatch_count = 0;
            beat_index     = 0;
        endfunction

        function int outstanding();
            return sorted_beats.size();
        endfunction

        task report_mismatch(input string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("MISMATCH at result beat %0d: %s", beat_index, msg);
        endtask

        // Stores an accepted value; a last beat sorts the set and queues its beats.
        function void note_item(bums_item_t beat);
            logic [63:0]        raw;
            logic [63:0]        value_mask;
            logic signed [63:0] key;
            bums_result_t       res;
            int                 i;
            int                 j;
            raw        = 64'(beat.value);
            value_mask = (64'd1 << DATA_WIDTH) - 64'd1;
            // Values past capacity are dropped, even on the last beat.
            if (open_set.size() < DEPTH)
            begin
                raw = raw << (64 - DATA_WIDTH);
                open_set.push_back($signed(raw) >>> (64 - DATA_WIDTH));
            end
            if (beat.last)
            begin
                // Stable ascending sort on the sign-extended values.
                for (i = 1; i < open_set.size(); i++)
                begin
                    key = open_set[i];
                    j   = i - 1;
                    while (j >= 0 && open_set[j] > key)
                    begin
                        open_set[j + 1] = open_set[j];
                        j--;
                    end
                    open_set[j + 1] = key;
                end
                for (i = 0; i < open_set.size(); i++)
                begin
                    res.sorted_value = VALUE_W'(open_set[i] & value_mask);
                    res.end_of_list  = (i == open_set.size() - 1);
                    sorted_beats.push_back(res);
                end
                open_set.delete();
            end
        endfunction

        // Compares one accepted result beat with the oldest expected beat.
        task check_result(input bums_result_t got);
            bums_result_t want;
            if (sorted_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, value %0d end %0b",
                                          got.sorted_value, got.end_of_list));
            end
            else
            begin
                want = sorted_beats.pop_front();
                if (got.sorted_value !== want.sorted_value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              got.sorted_value, want.sorted_value));
                if (got.end_of_list !== want.end_of_list)
                    report_mismatch($sformatf("end_of_list %0b, expected %0b",
                                              got.end_of_list, want.end_of_list));
            end
            beat_index++;
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    bums_item_t   item;
    logic         result_valid;
    logic         result_stall;
    bums_result_t result;

    int sender_idle_pct;
    int receiver_idle_pct;
    bit hold_request;

    sorted_set_scoreboard sb = new();

    bottom_up_merge_sorter_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Record accepted beats on both channels; results are checked first.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (rst_n && item_valid && !item_stall)
            sb.note_item(item);
    end

    // Receiver: random stalls, plus one long hold when requested.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offers one beat, with optional idle cycles first, and waits for acceptance.
    task automatic send_beat(input word_t value, input bit last);
        bums_item_t beat;
        beat.value = value;
        beat.last  = last;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= beat;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
    endtask

    function automatic word_t pick_value(input fill_mode_t mode);
        case (mode)
            FILL_NARROW:
                return word_t'(int'($urandom_range(8)) - 4);
            FILL_EXTREME:
                case ($urandom_range(6))
                    0:       return {1'b1, {(VALUE_W - 1){1'b0}}};
                    1:       return {1'b0, {(VALUE_W - 1){1'b1}}};
                    2:       return {1'b1, {(VALUE_W - 2){1'b0}}, 1'b1};
                    3:       return {1'b0, {(VALUE_W - 2){1'b1}}, 1'b0};
                    4:       return '0;
                    5:       return '1;
                    default: return word_t'(1);
                endcase
            default:
                return word_t'($urandom());
        endcase
    endfunction

    task automatic send_set(input int length, input fill_mode_t mode);
        for (int i = 0; i < length; i++)
            send_beat(pick_value(mode), i == length - 1);
    endtask

    initial
    begin
        int         counted;
        int         set_index;
        int         length;
        bit         hold_done;
        fill_mode_t mode;

        rst_n             = 1'b0;
        item_valid        = 1'b0;
        item              = '0;
        hold_request      = 1'b0;
        sender_idle_pct   = 22;
        receiver_idle_pct = 53;
        counted           = 0;
        set_index         = 0;
        hold_done         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single value set.
        send_beat(7, 1'b1);
        // Field extremes, zero and minus one.
        send_beat({1'b0, {(VALUE_W - 1){1'b1}}}, 1'b0);
        send_beat({1'b1, {(VALUE_W - 1){1'b0}}}, 1'b0);
        send_beat(0, 1'b0);
        send_beat(-1, 1'b0);
        send_beat(1, 1'b1);
        // Repeated values, so ties occur in the later merge passes.
        send_beat(5, 1'b0);
        send_beat(-3, 1'b0);
        send_beat(5, 1'b0);
        send_beat(-3, 1'b0);
        send_beat(5, 1'b1);
        // Already ascending.
        send_beat(-8, 1'b0);
        send_beat(-4, 1'b0);
        send_beat(0, 1'b0);
        send_beat(4, 1'b1);
        // Descending.
        send_beat(9, 1'b0);
        send_beat(6, 1'b0);
        send_beat(3, 1'b1);
        // Two equal minimum values.
        send_beat({1'b1, {(VALUE_W - 1){1'b0}}}, 1'b0);
        send_beat({1'b1, {(VALUE_W - 1){1'b0}}}, 1'b1);

        // Random sets: mostly partial, regularly full and over capacity.
        while (counted < ITEM_TARGET)
        begin
            if (counted < ITEM_TARGET / 3)
            begin
                sender_idle_pct   = 22;
                receiver_idle_pct = 53;
            end
            else if (counted < 2 * ITEM_TARGET / 3)
            begin
                sender_idle_pct   = 53;
                receiver_idle_pct = 22;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            length = $urandom_range(DEPTH - 1, 1);
            if (set_index % 7 == 3)
                length = DEPTH + $urandom_range(4, 1);
            else if (set_index % 7 == 5)
                length = DEPTH;
            // One full set under a long receiver hold, so the input backs up.
            if (!hold_done && counted >= 2 * ITEM_TARGET / 3)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
                length       = DEPTH;
            end
            mode = fill_mode_t'($urandom_range(2));
            send_set(length, mode);
            counted += (length > DEPTH) ? DEPTH : length;
            set_index++;
        end
        item_valid <= 1'b0;

        // Drain, then give a stray beat time to show up.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/core/bums_pkg.sv
rtl/core/bums_merge_engine.sv
rtl/core/bottom_up_merge_sorter_unit.sv
rtl/core/bums_checker.sv
tb/bottom_up_merge_sorter_unit_test.sv
